[src/kmp_pkg.sv]
// kmp_pkg: shared types and constants for the streaming kmp dna matcher
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

	localparam int SYM_W     = 2;
	localparam int PAT_W     = 64;
	localparam int LEN_W     = 6;
	localparam int START_W   = 32;
	localparam int CMP_W     = 48;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SYMBOLS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUILD,
		ST_SEARCH
	} state_t;

	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] length;
	} cfg_t;

endpackage

`default_nettype wire

[src/kmp_cfg_if.sv]
// kmp_cfg_if: configuration write channel (index and data)
// depends on kmp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kmp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [kmp_pkg::CFG_IDX_W-1:0]  index;
	logic [kmp_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/kmp_sym_if.sv]
// kmp_sym_if: text symbol input channel
// depends on kmp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kmp_sym_if;
	logic                       valid;
	logic                       ready;
	logic [kmp_pkg::SYM_W-1:0]  symbol;
	logic                       first;

	modport source (output valid, output symbol, output first, input ready);
	modport sink   (input valid, input symbol, input first, output ready);
endinterface

`default_nettype wire

[src/kmp_res_if.sv]
// kmp_res_if: per-symbol result channel
// depends on kmp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kmp_res_if;
	logic                         valid;
	logic                         ready;
	logic                         match;
	logic [kmp_pkg::START_W-1:0]  match_start;
	logic [kmp_pkg::CMP_W-1:0]    comparisons_total;

	modport source (output valid, output match, output match_start,
		output comparisons_total, input ready);
	modport sink   (input valid, input match, input match_start,
		input comparisons_total, output ready);
endinterface

`default_nettype wire

[src/kmp_dna_stream_matcher.sv]
// kmp_dna_stream_matcher: streaming kmp matcher over 2-bit dna symbols
// depends on kmp_pkg, kmp_*_if, kmp_cfg_regs, kmp_fail_table, kmp_cmp_unit
//
// channel   dir   payload                                      accepted when
// cfg       in    index, data                                  valid & ready
// text      in    symbol, first                                valid & ready
// result    out   match, match_start, comparisons_total        valid & ready
//
// one comparison per cycle through a single shared comparator
// symbol: accepted in idle, then one search compare per fallback plus a final compare
// first symbol adds a table rebuild in the build state before search
// text is not ready while a symbol is in flight; a stalled result holds search
// reset clears latched pattern to zeros, length 1, failure table to zeros
`timescale 1ns / 1ps
`default_nettype none

module kmp_dna_stream_matcher #(
	parameter int MAX_PATTERN    = 32,
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	kmp_cfg_if.sink   cfg,
	kmp_sym_if.sink   text,
	kmp_res_if.source result
);

	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int QW = $clog2(MAX_PATTERN + 1);
	localparam int PW = POSITION_WIDTH;
	localparam int SW = kmp_pkg::START_W;
	localparam int LW = kmp_pkg::LEN_W;

	kmp_pkg::state_t state_q, state_d;
	kmp_pkg::cfg_t   regs;

	logic [kmp_pkg::SYM_W-1:0] sym_q;
	logic [kmp_pkg::PAT_W-1:0] pat_q;
	logic [QW-1:0]             len_q;
	logic [QW-1:0]             q_q;
	logic [QW-1:0]             bk_q;
	logic [QW-1:0]             bq_q;
	logic [PW-1:0]             pos_q;
	logic [kmp_pkg::CMP_W-1:0] cnt_q;

	logic                      res_valid_q;
	logic                      res_match_q;
	logic [SW-1:0]             res_start_q;
	logic [kmp_pkg::CMP_W-1:0] res_cmp_q;

	logic                      eq;
	logic [IW-1:0]             idx_a;
	logic [QW-1:0]             rd_idx;
	logic [QW-1:0]             tbl_rd;
	logic [QW-1:0]             bk_next;
	logic [QW-1:0]             q_next;
	logic                      hit;
	logic                      fallback;
	logic                      out_free;
	logic [kmp_pkg::CMP_W-1:0] cnt_inc;
	logic [kmp_pkg::CMP_W-1:0] cnt_fin;
	logic [LW-1:0]             eff_len;
	logic [PW-1:0]             start_pw;

	logic text_ready;
	logic ld_item;
	logic bld_fall;
	logic bld_adv;
	logic srch_fall;
	logic srch_fin;

	kmp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	kmp_cmp_unit #(.IW(IW)) u_cmp (
		.pattern  (pat_q),
		.idx_a    (idx_a),
		.idx_b    (bq_q[IW-1:0]),
		.text_sym (sym_q),
		.sel_text (state_q != kmp_pkg::ST_BUILD),
		.eq       (eq)
	);

	kmp_fail_table #(.DEPTH(MAX_PATTERN), .AW(IW), .DW(QW)) u_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (bld_adv),
		.waddr  (bq_q[IW-1:0]),
		.wdata  (bk_next),
		.raddr  (rd_idx[IW-1:0]),
		.rdata  (tbl_rd)
	);

	// datapath terms
	always_comb begin
		idx_a    = (state_q == kmp_pkg::ST_BUILD) ? bk_q[IW-1:0] : q_q[IW-1:0];
		fallback = (q_q != '0) && !eq;
		if (state_q == kmp_pkg::ST_BUILD) begin
			rd_idx = bk_q - QW'(1);
		end else if (fallback) begin
			rd_idx = q_q - QW'(1);
		end else begin
			rd_idx = q_q;
		end
		bk_next  = bk_q + QW'(eq);
		q_next   = q_q + QW'(eq);
		hit      = (q_next == len_q);
		out_free = !res_valid_q || result.ready;
		cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + kmp_pkg::CMP_W'(1);
		// a finish at a nonzero state counts the loop compare and the final one
		if (q_q == '0) begin
			cnt_fin = cnt_inc;
		end else if (&cnt_q[kmp_pkg::CMP_W-1:1]) begin
			cnt_fin = '1;
		end else begin
			cnt_fin = cnt_q + kmp_pkg::CMP_W'(2);
		end
		start_pw = pos_q + PW'(1) - PW'(len_q);
		if (regs.length == '0) begin
			eff_len = LW'(1);
		end else if (regs.length > LW'(MAX_PATTERN)) begin
			eff_len = LW'(MAX_PATTERN);
		end else begin
			eff_len = regs.length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		text_ready = 1'b0;
		ld_item    = 1'b0;
		bld_fall   = 1'b0;
		bld_adv    = 1'b0;
		srch_fall  = 1'b0;
		srch_fin   = 1'b0;
		case (state_q)
			kmp_pkg::ST_IDLE: begin
				text_ready = 1'b1;
				if (text.valid) begin
					ld_item = 1'b1;
					state_d = text.first ? kmp_pkg::ST_BUILD : kmp_pkg::ST_SEARCH;
				end
			end
			kmp_pkg::ST_BUILD: begin
				if (bq_q >= len_q) begin
					state_d = kmp_pkg::ST_SEARCH;
				end else if ((bk_q != '0) && !eq) begin
					bld_fall = 1'b1;
				end else begin
					bld_adv = 1'b1;
				end
			end
			kmp_pkg::ST_SEARCH: begin
				if (fallback) begin
					srch_fall = 1'b1;
				end else if (out_free) begin
					srch_fin = 1'b1;
					state_d  = kmp_pkg::ST_IDLE;
				end
			end
			default: state_d = kmp_pkg::ST_IDLE;
		endcase
	end

	assign text.ready = text_ready;

	// item and match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= QW'(1);
			q_q   <= '0;
			bk_q  <= '0;
			bq_q  <= '0;
			pos_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ld_item && text.first) begin
				pat_q <= regs.pattern;
				len_q <= QW'(eff_len);
				q_q   <= '0;
				bk_q  <= '0;
				bq_q  <= QW'(1);
				pos_q <= '0;
				cnt_q <= '0;
			end
			if (bld_fall) begin
				bk_q <= tbl_rd;
			end
			if (bld_adv) begin
				bk_q <= bk_next;
				bq_q <= bq_q + QW'(1);
			end
			if (srch_fall) begin
				q_q   <= tbl_rd;
				cnt_q <= cnt_inc;
			end
			if (srch_fin) begin
				q_q   <= hit ? tbl_rd : q_next;
				cnt_q <= cnt_fin;
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_item) begin
			sym_q <= text.symbol;
		end
		if (srch_fin) begin
			res_match_q <= hit;
			res_start_q <= hit ? SW'(start_pw) : '0;
			res_cmp_q   <= cnt_fin;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (srch_fin) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.match             = res_match_q;
	assign result.match_start       = res_start_q;
	assign result.comparisons_total = res_cmp_q;

endmodule

`default_nettype wire

[src/kmp_cfg_regs.sv]
// kmp_cfg_regs: pattern and length registers behind the config channel
// depends on kmp_pkg, kmp_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module kmp_cfg_regs (
	input  wire logic       clk,
	input  wire logic       arst_n,
	kmp_cfg_if.sink         cfg,
	output kmp_pkg::cfg_t   regs
);

	kmp_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pattern <= '0;
			regs_q.length  <= kmp_pkg::LEN_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				kmp_pkg::REG_PATTERN_SYMBOLS: regs_q.pattern <= cfg.data;
				kmp_pkg::REG_PATTERN_LENGTH:  regs_q.length  <= cfg.data[kmp_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/kmp_fail_table.sv]
// kmp_fail_table: failure table storage, one write and one read per cycle
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module kmp_fail_table #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] entry_q [DEPTH];

	assign rdata = entry_q[raddr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				entry_q[i] <= '0;
			end
		end else if (we) begin
			entry_q[waddr] <= wdata;
		end
	end

endmodule

`default_nettype wire

[src/kmp_cmp_unit.sv]
// kmp_cmp_unit: shared symbol comparator for table build and text search
// depends on kmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmp_cmp_unit #(
	parameter int IW = 5
) (
	input  wire logic [kmp_pkg::PAT_W-1:0] pattern,
	input  wire logic [IW-1:0]             idx_a,
	input  wire logic [IW-1:0]             idx_b,
	input  wire logic [kmp_pkg::SYM_W-1:0] text_sym,
	input  wire logic                      sel_text,
	output logic                           eq
);

	logic [kmp_pkg::SYM_W-1:0] sym_a;
	logic [kmp_pkg::SYM_W-1:0] sym_b;

	always_comb begin
		sym_a = pattern[{idx_a, 1'b0} +: kmp_pkg::SYM_W];
		sym_b = sel_text ? text_sym : pattern[{idx_b, 1'b0} +: kmp_pkg::SYM_W];
		eq    = (sym_a == sym_b);
	end

endmodule

`default_nettype wire

[src/kmp_checker.sv]
// kmp_checker: port-level checks on the matcher, bound to the top level
// depends on kmp_pkg, kmp_dna_stream_matcher
`timescale 1ns / 1ps
`default_nettype none

module kmp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         out_match,
	input wire logic [kmp_pkg::START_W-1:0]  out_start,
	input wire logic [kmp_pkg::CMP_W-1:0]    out_cmp
);

	// result word held until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// one symbol in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("text ready right after accepting a word");

	// no match means zero start
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_match |-> out_start == '0)
		else $error("match_start nonzero without a match");

	// every symbol costs at least one comparison
	a_cmp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_cmp != '0)
		else $error("comparison count zero on a result word");

endmodule

bind kmp_dna_stream_matcher kmp_checker u_kmp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text.valid),
	.in_ready  (text.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_match (result.match),
	.out_start (result.match_start),
	.out_cmp   (result.comparisons_total)
);

`default_nettype wire
